FILE: hdl/fire_effect_row_propagator_assert.svh
`ifndef FIRE_EFFECT_ROW_PROPAGATOR_ASSERT_SVH
`define FIRE_EFFECT_ROW_PROPAGATOR_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define FERP_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define FERP_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: hdl/ferp_pkg.sv
`timescale 1ns / 1ps

package ferp_pkg;

    localparam int INDEX_W     = 8;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 10;
    localparam int PROD_W      = 20;
    localparam int M_DATA_W    = 40;
    localparam int RESET_WIDTH = 640;

    // floor(x / 3) == (x * 683) >> 11 for x below 2048
    localparam int DIV3_MUL    = 683;
    localparam int DIV3_SHIFT  = 11;

    localparam logic [2:0] SEG_BLUE       = 3'd0;
    localparam logic [2:0] SEG_BLUE_RED   = 3'd1;
    localparam logic [2:0] SEG_RED_YELLOW = 3'd2;
    localparam logic [2:0] SEG_WHITE_0    = 3'd3;
    localparam logic [2:0] SEG_WHITE_1    = 3'd4;
    localparam logic [2:0] SEG_WHITE_2    = 3'd5;
    localparam logic [2:0] SEG_WHITE_3    = 3'd6;

    typedef logic [INDEX_W-1:0] index_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    function automatic rgba_t fire_palette(input index_t idx);
        rgba_t      c;
        logic [4:0] i;
        i       = idx[4:0];
        c.red   = 8'hFF;
        c.green = 8'hFF;
        c.blue  = 8'h00;
        c.alpha = 8'hFF;
        case (idx[7:5])
            SEG_BLUE: begin
                c.red   = 8'h00;
                c.green = 8'h00;
                c.blue  = 8'hFF;
                c.alpha = {i, 3'b000};
            end
            SEG_BLUE_RED: begin
                c.red   = {i, 3'b000};
                c.green = 8'h00;
                c.blue  = 8'd64 - {2'b00, i, 1'b0};
            end
            SEG_RED_YELLOW: begin
                c.green = {i, 3'b000};
                c.blue  = 8'h00;
            end
            SEG_WHITE_0: c.blue = {1'b0, i, 2'b00};
            SEG_WHITE_1: c.blue = 8'd64 + {1'b0, i, 2'b00};
            SEG_WHITE_2: c.blue = 8'd128 + {1'b0, i, 2'b00};
            SEG_WHITE_3: c.blue = 8'd192 + {3'b000, i};
            default:     c.blue = 8'd224 + {3'b000, i};
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/fire_effect_row_propagator.sv
`timescale 1ns / 1ps

// Fire effect row propagator. Takes one pixel word per clock, bottom row first, columns
// ascending, and returns one word per pixel with the new palette index and its RGBA color.
// Sustained rate is one pixel per clock. When an input word is taken, the input register
// and the registered read of the row memory load on the same edge; the compute stage then
// feeds the output register, which drives m_tvalid. The input stalls only while both the
// input register and the output register are full and m_tready is low.
// The row below and the row in progress share one RAM of two banks of
// 2**ceil(log2(MAX_WIDTH)) bytes; there is no clearing pass, so the first non-bottom row
// after reset must follow a bottom row. Writing active_width (clamped to 2..MAX_WIDTH)
// restarts at column 0 and keeps the bank order; write it only while no pixel is in flight.
module fire_effect_row_propagator #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ferp_pkg::INDEX_W-1:0]  s_tdata,   // [7:0] old_index
    input  logic                          s_tuser,   // [0] bottom_row
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ferp_pkg::M_DATA_W-1:0] m_tdata,   // new_index, red, green, blue, alpha
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ferp_pkg::CFG_W-1:0]    cfg_data   // active_width
);

    import ferp_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int CMPW       = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RAM_AW     = CW + 1;
    localparam int RAM_DEPTH  = 2 ** RAM_AW;
    localparam int RESET_LAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

    logic [CW-1:0] col_reg, col_next;
    logic          sel_reg, sel_next;
    logic [CW-1:0] last_col_reg, last_col_next;

    logic          s1_valid_reg;
    index_t        s1_old_reg;
    logic          s1_bottom_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_sel_reg;
    logic          s1_left_reg;
    logic          s1_right_reg;

    index_t        win_l_reg, win_m_reg;
    index_t        row0_reg [2];

    logic          m_valid_reg;
    index_t        res_reg, res_next;
    logic          res_bank_reg;
    logic [CW-1:0] res_col_reg;
    logic          res_seen_reg;

    logic          s_accept, out_load;
    index_t        ram_q;
    logic [CMPW-1:0] cfg_ext;

    logic [CW-1:0]     col_p1;
    logic              fwd, cnt3, grow;
    index_t            nb_l, nb_m, nb_r, val;
    logic [SUM_W-1:0]  sum, old_p1, thr, x;
    logic [PROD_W-1:0] prod;
    index_t            q3, q4;
    rgba_t             pal;

    assign out_load  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || out_load;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp width, keep last column
    assign cfg_ext = CMPW'(cfg_data);
    always_comb begin
        if (cfg_ext < CMPW'(2)) begin
            last_col_next = CW'(1);
        end else if (cfg_ext > CMPW'(MAX_WIDTH)) begin
            last_col_next = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_next = CW'(cfg_ext - CMPW'(1));
        end
    end

    always_comb begin
        col_next = col_reg;
        sel_next = sel_reg;
        if (cfg_valid) begin
            col_next = '0;
        end else if (s_accept) begin
            if (col_reg == last_col_reg) begin
                col_next = '0;
                sel_next = !sel_reg;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            sel_reg      <= 1'b0;
            last_col_reg <= CW'(RESET_LAST);
        end else begin
            col_reg <= col_next;
            sel_reg <= sel_next;
            if (cfg_valid) begin
                last_col_reg <= last_col_next;
            end
        end
    end

    ferp_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (RAM_DEPTH)
    ) u_row_ram (
        .clk   (aclk),
        .we    (out_load),
        .waddr ({!s1_sel_reg, s1_col_reg}),
        .wdata (res_next),
        .re    (s_accept),
        .raddr ({sel_reg, col_reg + CW'(1)}),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (out_load) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_old_reg    <= s_tdata;
            s1_bottom_reg <= s_tuser;
            s1_col_reg    <= col_reg;
            s1_sel_reg    <= sel_reg;
            s1_left_reg   <= (col_reg == '0);
            s1_right_reg  <= (col_reg == last_col_reg);
        end
    end

    // resolve neighbors: left edge from bank row0 copy, right from RAM or last result
    assign col_p1 = s1_col_reg + CW'(1);
    assign fwd    = res_seen_reg && (res_bank_reg == s1_sel_reg) && (res_col_reg == col_p1);
    assign nb_l   = s1_left_reg  ? '0 : win_l_reg;
    assign nb_m   = s1_left_reg  ? row0_reg[s1_sel_reg] : win_m_reg;
    assign nb_r   = fwd ? res_reg : ram_q;
    assign cnt3   = !s1_left_reg && !s1_right_reg;

    always_comb begin
        sum    = SUM_W'(nb_l) + SUM_W'(nb_m) + (s1_right_reg ? '0 : SUM_W'(nb_r));
        old_p1 = SUM_W'(s1_old_reg) + SUM_W'(1);
        thr    = cnt3 ? (old_p1 << 1) + old_p1 : (old_p1 << 1);
        grow   = (sum >= thr);
        x      = sum + SUM_W'(s1_old_reg);
        prod   = PROD_W'(x) * PROD_W'(DIV3_MUL);
        q3     = prod[DIV3_SHIFT +: INDEX_W];
        q4     = x[2 +: INDEX_W];
        val    = grow ? (cnt3 ? q4 : q3) : s1_old_reg;
        if (s1_bottom_reg) begin
            res_next = s1_old_reg;
        end else if (val == '0) begin
            res_next = '0;
        end else begin
            res_next = val - INDEX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            win_l_reg    <= nb_m;
            win_m_reg    <= nb_r;
            res_reg      <= res_next;
            res_bank_reg <= !s1_sel_reg;
            res_col_reg  <= s1_col_reg;
            if (s1_left_reg) begin
                row0_reg[!s1_sel_reg] <= res_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            res_seen_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg  <= 1'b1;
                res_seen_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign pal      = fire_palette(res_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {pal, res_reg};

endmodule

FILE: hdl/ferp_ram.sv
`timescale 1ns / 1ps

module ferp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/ferp_checker.sv
`timescale 1ns / 1ps

`include "fire_effect_row_propagator_assert.svh"

module ferp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ferp_pkg::M_DATA_W-1:0] m_tdata
);

    import ferp_pkg::*;

    `FERP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `FERP_ASSERT_NOW(a_no_idle_stall, !s_tready,
        m_tvalid && !m_tready, "input stalled without output backpressure")
    `FERP_ASSERT_NOW(a_low_alpha, m_tvalid && (m_tdata[7:5] == SEG_BLUE),
        (m_tdata[39:32] == {m_tdata[4:0], 3'b000}) && (m_tdata[31:8] == 24'hFF0000),
        "blue segment color wrong")
    `FERP_ASSERT_NOW(a_opaque, m_tvalid && (m_tdata[7:5] != SEG_BLUE),
        m_tdata[39:32] == 8'hFF, "upper palette not opaque")

endmodule

bind fire_effect_row_propagator ferp_checker u_ferp_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ferp_pkg::*;

    localparam int MAX_W           = 1024;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_ITEMS    = 640;

    class fire_row_tracker;
        index_t              heat_rows [2][MAX_W];
        int unsigned         column;
        bit                  below_sel;
        int unsigned         width_reg;
        logic [M_DATA_W-1:0] expected_pixels [$];
        int unsigned         errors;

        function new();
            column    = 0;
            below_sel = 1'b0;
            width_reg = RESET_WIDTH;
            errors    = 0;
        endfunction

        static function int unsigned clamp_width(int unsigned w);
            if (w < 2) return 2;
            if (w > MAX_W) return MAX_W;
            return w;
        endfunction

        function logic [31:0] fire_color(index_t lvl);
            logic [7:0] r, g, b, a, i;
            i = {3'b000, lvl[4:0]};
            r = 8'd255;
            g = 8'd255;
            b = 8'd0;
            a = 8'd255;
            case (lvl[7:5])
                SEG_BLUE: begin
                    r = 8'd0;
                    g = 8'd0;
                    b = 8'd255;
                    a = i << 3;
                end
                SEG_BLUE_RED: begin
                    r = i << 3;
                    g = 8'd0;
                    b = 8'd64 - (i << 1);
                end
                SEG_RED_YELLOW: begin
                    g = i << 3;
                    b = 8'd0;
                end
                SEG_WHITE_0: b = i << 2;
                SEG_WHITE_1: b = 8'd64 + (i << 2);
                SEG_WHITE_2: b = 8'd128 + (i << 2);
                SEG_WHITE_3: b = 8'd192 + i;
                default:     b = 8'd224 + i;
            endcase
            return {a, b, g, r};
        endfunction

        function void take_width(logic [CFG_W-1:0] w);
            width_reg = w;
            column    = 0;
        endfunction

        function void take_pixel(index_t heat, bit bottom);
            int unsigned w, c, sum, cnt, old;
            index_t      lvl;
            w   = clamp_width(width_reg);
            c   = (column >= w) ? w - 1 : column;
            old = heat;
            if (bottom) begin
                lvl = heat;
            end else begin
                if (c == 0) begin
                    sum = heat_rows[below_sel][0] + heat_rows[below_sel][1];
                    cnt = 2;
                end else if (c == w - 1) begin
                    sum = heat_rows[below_sel][c-1] + heat_rows[below_sel][c];
                    cnt = 2;
                end else begin
                    sum = heat_rows[below_sel][c-1] + heat_rows[below_sel][c]
                        + heat_rows[below_sel][c+1];
                    cnt = 3;
                end
                if (sum / cnt > old) old = (sum + old) / (cnt + 1);
                lvl = index_t'((old > 0) ? old - 1 : 0);
            end
            heat_rows[!below_sel][c] = lvl;
            if (c + 1 >= w) begin
                column    = 0;
                below_sel = !below_sel;
            end else begin
                column = c + 1;
            end
            expected_pixels.push_back({fire_color(lvl), lvl});
        endfunction

        function void check_pixel(logic [M_DATA_W-1:0] got);
            logic [M_DATA_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                if (errors < 32) $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
                if (errors < 32) begin
                    $display("%0t: expected idx %0d rgba %h, got idx %0d rgba %h",
                             $time, want[7:0], want[39:8], got[7:0], got[39:8]);
                end
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [INDEX_W-1:0]  s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    int unsigned     tx_idle_pct  = 25;
    int unsigned     rx_idle_pct  = 46;
    int unsigned     pixels_sent  = 0;
    bit              hold_off_req = 1'b0;
    fire_row_tracker tracker      = new();

    fire_effect_row_propagator #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sample handshakes on the falling edge ahead of the edge that takes them
    always @(negedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.take_width(cfg_data);
            if (s_tvalid && s_tready) tracker.take_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready) tracker.check_pixel(m_tdata);
        end
    end

    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** fire_effect_row_propagator: FAILED **");
        $finish;
    end

    function automatic index_t pick_heat();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return index_t'($urandom_range(31));
            default: return index_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input index_t heat, input bit bottom);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= heat;
        s_tuser  <= bottom;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        pixels_sent++;
    endtask

    // lowest byte goes first
    task automatic send_heats(input logic [63:0] heats, input int unsigned n, input bit bottom);
        for (int unsigned k = 0; k < n; k++) send_pixel(heats[8*k +: 8], bottom);
    endtask

    // drain the pipe before touching the width
    task automatic write_width(input logic [CFG_W-1:0] w);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // seed a full bottom row, then hot rows above; the last row may stop short
    task automatic random_frame(input logic [CFG_W-1:0] cfg);
        int unsigned w, rows, len;
        w    = fire_row_tracker::clamp_width(cfg);
        rows = $urandom_range(6, 2);
        write_width(cfg);
        for (int unsigned r = 0; r < rows; r++) begin
            len = w;
            if (r == rows - 1 && $urandom_range(3) == 0) len = $urandom_range(w, 1);
            for (int unsigned c = 0; c < len; c++)
                send_pixel(pick_heat(), r == 0 || $urandom_range(19) == 0);
        end
    endtask

    initial begin : stimulus
        int unsigned      random_start;
        logic [CFG_W-1:0] cfg;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // palette segment starts other than 0x20, plus 0xFF, at the reset width
        send_heats(64'hFF_E0_C0_A0_80_60_40_00, 8, 1'b1);
        write_width(11'd0);
        send_heats(64'h00FF, 2, 1'b1);
        send_heats(64'hFF00, 2, 1'b0);
        send_heats(64'h0000, 2, 1'b0);
        write_width(11'd3);
        send_heats(64'hFFFFFF, 3, 1'b1);
        send_heats(64'h00FF00, 3, 1'b0);
        send_heats(64'h000000, 3, 1'b1);
        send_heats(64'h000000, 3, 1'b0);

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            if (pixels_sent - random_start >= 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (pixels_sent - random_start >= RANDOM_ITEMS / 3) begin
                tx_idle_pct = 46;
                rx_idle_pct = 25;
            end
            case ($urandom_range(9))
                0:       cfg = CFG_W'($urandom_range(1));
                1:       cfg = CFG_W'($urandom_range(40, 13));
                default: cfg = CFG_W'($urandom_range(12, 2));
            endcase
            random_frame(cfg);
        end

        // clamped width, then hold the result side so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_width(11'h7FF);
        repeat (24) send_pixel(pick_heat(), 1'b1);
        write_width(11'd24);
        hold_off_req = 1'b1;
        repeat (24) send_pixel(pick_heat(), 1'b1);
        repeat (26) send_pixel(pick_heat(), 1'b0);

        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("** fire_effect_row_propagator: PASSED **");
        end else begin
            $display("** fire_effect_row_propagator: FAILED **");
        end
        $finish;
    end
endmodule
